>>> rtl/rafp_pkg.sv
package rafp_pkg;

  localparam int MAX_REGIONS_DEF = 64;
  localparam int PAGE_BYTES_DEF  = 4096;

  localparam int ADDR_W    = 20;
  localparam int SIZE_W    = 21;
  localparam int END_W     = 22;   // region end / gap math, one bit of headroom
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;
  localparam int POOL_CAP  = 1048576;

  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_FREE  = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_MISS = 2'd1;
  localparam logic [1:0] STATUS_OFF  = 2'd2;

  localparam logic [1:0] POLICY_BEST  = 2'd1;
  localparam logic [1:0] POLICY_WORST = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGES   = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [SIZE_W-1:0] len;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_EV,
    S_DECIDE,
    S_SH_RD,
    S_SH_WR,
    S_LG_RD,
    S_LG_EV,
    S_FIN
  } state_t;

endpackage

>>> rtl/region_allocator_fit_policies_unit.sv
// Channel  | valid     | stall     | word
// ---------+-----------+-----------+------------------------------------------
// request  | req_valid | req_stall | kind, request_size, address
// response | rsp_valid | rsp_stall | status, region_start, region_size,
//          |           |           | is_inside, largest_gap, free_bytes
// config   | cfg_we    | -         | cfg_index, cfg_data
//
// One word at a time. With n regions in the table, a request walks the table
// in passes (a read state, then a compare state per entry); alloc and free
// also move entries (a read and a write state per entry moved), plus a final
// walk for the largest gap. The single read port of the table sets this pace.
// Sync reset empties the table at once (count cleared); no clearing pass.
// The response sits in an output register; a new request is taken while it
// waits, and a finished response waits in FIN while the last one is held by rsp_stall.
module region_allocator_fit_policies_unit #(
  parameter int MAX_REGIONS = rafp_pkg::MAX_REGIONS_DEF,
  parameter int PAGE_BYTES  = rafp_pkg::PAGE_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [rafp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rafp_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  logic [1:0]                        kind,
  input  logic [rafp_pkg::SIZE_W-1:0]       request_size,
  input  logic [rafp_pkg::ADDR_W-1:0]       address,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output logic [1:0]                        status,
  output logic [rafp_pkg::ADDR_W-1:0]       region_start,
  output logic [rafp_pkg::SIZE_W-1:0]       region_size,
  output logic                              is_inside,
  output logic [rafp_pkg::SIZE_W-1:0]       largest_gap,
  output logic [rafp_pkg::SIZE_W-1:0]       free_bytes
);
  import rafp_pkg::*;

  localparam int IDX_W  = $clog2(MAX_REGIONS);
  localparam int CNT_W  = $clog2(MAX_REGIONS + 1);
  localparam int PAGE_W = $clog2(PAGE_BYTES + 1);
  localparam int PROD_W = CFG_W + PAGE_W;

  // config
  logic              enabled, enabled_next;
  logic [1:0]        fit_policy, fit_policy_next;
  logic [SIZE_W-1:0] pool_size, pool_size_next;

  // table state
  logic [CNT_W-1:0]  count, count_next;
  logic [SIZE_W-1:0] bytes_free, bytes_free_next;

  // sequencer
  state_t            state, state_next;
  logic [CNT_W-1:0]  idx, idx_next;
  logic [END_W-1:0]  prev_end, prev_end_next;
  logic              found, found_next;
  logic [CNT_W-1:0]  slot, slot_next;
  logic [ADDR_W-1:0] slot_start, slot_start_next;
  logic [END_W-1:0]  best, best_next;
  logic [SIZE_W-1:0] hit_len, hit_len_next;
  logic [END_W-1:0]  lg, lg_next;

  // latched request
  logic [1:0]        op, op_next;
  logic [SIZE_W-1:0] op_size, op_size_next;
  logic [ADDR_W-1:0] op_addr, op_addr_next;

  // pending result
  logic [1:0]        res_status, res_status_next;
  logic [ADDR_W-1:0] res_start, res_start_next;
  logic [SIZE_W-1:0] res_rsize, res_rsize_next;
  logic              res_inside, res_inside_next;

  logic rsp_valid_next;

  // table port
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr, mem_raddr;
  entry_t            mem_wdata, mem_rdata;

  rafp_table #(.DEPTH(MAX_REGIONS), .IDX_W(IDX_W)) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // pool size from a pages write; 0 pages means 1, capped at POOL_CAP
  logic [CFG_W-1:0]  cfg_pages;
  logic [PROD_W-1:0] pool_prod;
  logic [SIZE_W-1:0] pool_new;

  assign cfg_pages = (cfg_data == '0) ? CFG_W'(1) : cfg_data;
  assign pool_prod = PROD_W'(cfg_pages) * PROD_W'(PAGE_BYTES);
  assign pool_new  = (32'(pool_prod) > 32'(POOL_CAP)) ? SIZE_W'(POOL_CAP)
                                                       : SIZE_W'(pool_prod);

  // shared gap unit: tail gap in the read states, inner gap in the eval states
  logic              on_tail;
  logic [END_W-1:0]  gap_hi, gap, entry_end;
  logic              gap_fit, take, is_first, hit;

  assign on_tail   = (idx == count);
  assign gap_hi    = (state == S_SCAN_RD || state == S_LG_RD) ? END_W'(pool_size)
                                                              : END_W'(mem_rdata.start);
  assign gap       = (gap_hi >= prev_end) ? gap_hi - prev_end : '0;
  assign entry_end = END_W'(mem_rdata.start) + END_W'(mem_rdata.len);
  assign gap_fit   = gap >= END_W'(op_size);
  assign is_first  = (fit_policy != POLICY_BEST) && (fit_policy != POLICY_WORST);
  assign take      = gap_fit && (is_first ||
                     (fit_policy == POLICY_BEST  && (!found || gap < best)) ||
                     (fit_policy == POLICY_WORST && (!found || gap > best)));
  assign hit       = (END_W'(mem_rdata.start) <= END_W'(op_addr)) &&
                     (END_W'(op_addr) < entry_end);

  logic [SIZE_W:0] free_sum;
  assign free_sum = {1'b0, bytes_free} + {1'b0, hit_len};

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next      = state;
    enabled_next    = enabled;
    fit_policy_next = fit_policy;
    pool_size_next  = pool_size;
    count_next      = count;
    bytes_free_next = bytes_free;
    idx_next        = idx;
    prev_end_next   = prev_end;
    found_next      = found;
    slot_next       = slot;
    slot_start_next = slot_start;
    best_next       = best;
    hit_len_next    = hit_len;
    lg_next         = lg;
    op_next         = op;
    op_size_next    = op_size;
    op_addr_next    = op_addr;
    res_status_next = res_status;
    res_start_next  = res_start;
    res_rsize_next  = res_rsize;
    res_inside_next = res_inside;
    rsp_valid_next  = rsp_valid && rsp_stall;
    mem_we          = 1'b0;
    mem_waddr       = '0;
    mem_wdata       = '0;
    mem_raddr       = idx[IDX_W-1:0];

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          op_next         = kind;
          op_size_next    = request_size;
          op_addr_next    = address;
          idx_next        = '0;
          prev_end_next   = '0;
          found_next      = 1'b0;
          best_next       = '0;
          lg_next         = '0;
          res_status_next = STATUS_MISS;
          res_start_next  = '0;
          res_rsize_next  = '0;
          res_inside_next = 1'b0;
          priority if (kind == KIND_ALLOC) begin
            if (!enabled) begin
              res_status_next = STATUS_OFF;
              state_next      = S_LG_RD;
            end else if (request_size == '0 || 32'(count) >= MAX_REGIONS) begin
              state_next = S_LG_RD;
            end else begin
              state_next = S_SCAN_RD;
            end
          end else if (kind == KIND_FREE || kind == KIND_QUERY) begin
            state_next = S_SCAN_RD;
          end else begin
            state_next = S_LG_RD;
          end
        end
      end

      S_SCAN_RD: begin
        if (on_tail) begin
          if (op == KIND_ALLOC && take) begin
            found_next      = 1'b1;
            slot_next       = idx;
            slot_start_next = prev_end[ADDR_W-1:0];
            best_next       = gap;
          end
          state_next = S_DECIDE;
        end else begin
          state_next = S_SCAN_EV;
        end
      end

      S_SCAN_EV: begin
        state_next    = S_SCAN_RD;
        prev_end_next = entry_end;
        idx_next      = idx + CNT_W'(1);
        if (op == KIND_ALLOC) begin
          if (take) begin
            found_next      = 1'b1;
            slot_next       = idx;
            slot_start_next = prev_end[ADDR_W-1:0];
            best_next       = gap;
            if (is_first) begin
              state_next = S_DECIDE;
            end
          end
        end else if (hit) begin
          found_next   = 1'b1;
          slot_next    = idx;
          hit_len_next = mem_rdata.len;
          state_next   = S_DECIDE;
        end
      end

      S_DECIDE: begin
        idx_next      = '0;
        prev_end_next = '0;
        state_next    = S_LG_RD;
        if (found) begin
          priority if (op == KIND_ALLOC) begin
            idx_next   = count;
            state_next = S_SH_RD;
          end else if (op == KIND_FREE) begin
            idx_next   = slot + CNT_W'(1);
            state_next = S_SH_RD;
          end else begin
            res_status_next = STATUS_OK;
            res_inside_next = 1'b1;
            res_rsize_next  = hit_len;
          end
        end
      end

      S_SH_RD: begin
        if (op == KIND_ALLOC) begin
          if (idx > slot) begin
            mem_raddr  = IDX_W'(idx - CNT_W'(1));
            state_next = S_SH_WR;
          end else begin
            mem_we          = 1'b1;
            mem_waddr       = slot[IDX_W-1:0];
            mem_wdata.start = slot_start;
            mem_wdata.len   = op_size;
            count_next      = count + CNT_W'(1);
            bytes_free_next = (bytes_free >= op_size) ? bytes_free - op_size : '0;
            res_status_next = STATUS_OK;
            res_start_next  = slot_start;
            idx_next        = '0;
            prev_end_next   = '0;
            state_next      = S_LG_RD;
          end
        end else begin
          if (idx < count) begin
            state_next = S_SH_WR;
          end else begin
            count_next      = count - CNT_W'(1);
            bytes_free_next = (free_sum > (SIZE_W+1)'(POOL_CAP)) ? SIZE_W'(POOL_CAP)
                                                                : free_sum[SIZE_W-1:0];
            res_status_next = STATUS_OK;
            idx_next        = '0;
            prev_end_next   = '0;
            state_next      = S_LG_RD;
          end
        end
      end

      S_SH_WR: begin
        mem_we     = 1'b1;
        mem_wdata  = mem_rdata;
        state_next = S_SH_RD;
        if (op == KIND_ALLOC) begin
          mem_waddr = idx[IDX_W-1:0];
          idx_next  = idx - CNT_W'(1);
        end else begin
          mem_waddr = IDX_W'(idx - CNT_W'(1));
          idx_next  = idx + CNT_W'(1);
        end
      end

      S_LG_RD: begin
        if (on_tail) begin
          if (gap > lg) lg_next = gap;
          state_next = S_FIN;
        end else begin
          state_next = S_LG_EV;
        end
      end

      S_LG_EV: begin
        if (gap > lg) lg_next = gap;
        prev_end_next = entry_end;
        idx_next      = idx + CNT_W'(1);
        state_next    = S_LG_RD;
      end

      S_FIN: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase

    // the user makes config writes only while idle; the block does not enforce it
    if (cfg_we) begin
      priority if (cfg_index == CFG_ENABLED) begin
        enabled_next = cfg_data[0];
      end else if (cfg_index == CFG_POLICY) begin
        fit_policy_next = cfg_data[1:0];
      end else if (cfg_index == CFG_PAGES) begin
        pool_size_next  = pool_new;
        bytes_free_next = pool_new;
        count_next      = '0;
      end else begin
        enabled_next = enabled;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      enabled    <= 1'b0;
      fit_policy <= '0;
      pool_size  <= SIZE_W'(PAGE_BYTES);
      bytes_free <= SIZE_W'(PAGE_BYTES);
      count      <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      enabled    <= enabled_next;
      fit_policy <= fit_policy_next;
      pool_size  <= pool_size_next;
      bytes_free <= bytes_free_next;
      count      <= count_next;
      rsp_valid  <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    prev_end   <= prev_end_next;
    found      <= found_next;
    slot       <= slot_next;
    slot_start <= slot_start_next;
    best       <= best_next;
    hit_len    <= hit_len_next;
    lg         <= lg_next;
    op         <= op_next;
    op_size    <= op_size_next;
    op_addr    <= op_addr_next;
    res_status <= res_status_next;
    res_start  <= res_start_next;
    res_rsize  <= res_rsize_next;
    res_inside <= res_inside_next;
    if (state == S_FIN && (!rsp_valid || !rsp_stall)) begin
      status       <= res_status;
      region_start <= res_start;
      region_size  <= res_rsize;
      is_inside    <= res_inside;
      largest_gap  <= SIZE_W'(lg);
      free_bytes   <= bytes_free;
    end
  end

  // checks
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= MAX_REGIONS) else $error("region count above table depth");

  a_free_le_pool: assert property (@(posedge clk) disable iff (rst)
    bytes_free <= pool_size) else $error("free bytes exceed pool size");

  a_rsp_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_FIN)) else $error("response outside FIN");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (state == S_SCAN_RD || state == S_LG_RD))
    else $error("accepted request did not start a walk");

endmodule

>>> rtl/rafp_table.sv
module rafp_table #(
  parameter int DEPTH = rafp_pkg::MAX_REGIONS_DEF,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [IDX_W-1:0]     waddr,
  input  rafp_pkg::entry_t     wdata,
  input  logic [IDX_W-1:0]     raddr,
  output rafp_pkg::entry_t     rdata
);
  import rafp_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
